[sv/lppm_pkg.sv]
// Shared types and constants of the line-position PID motor mixer.
`default_nettype none

package lppm_pkg;

   localparam int GAIN_W   = 16;
   localparam int INTEG_W  = 18;
   localparam int DUTY_W   = 7;
   localparam int TURN_W   = 16;
   localparam int MAX_DUTY = 100;

   localparam logic [2:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [2:0] CSR_INTEG_LIMIT = 3'd3;
   localparam logic [2:0] CSR_BASE_DUTY   = 3'd4;

   typedef enum logic [1:0] {
      SEL_ERR,
      SEL_INTEG,
      SEL_DIFF
   } mul_sel_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [15:0]              integ_limit;
      logic [DUTY_W-1:0]        base_duty;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        integ;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum_load;
      logic        sum_add;
      logic        turn_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic lost;
   } status_type;

endpackage

`default_nettype wire

[sv/lppm_ctrl.sv]
// Sequencer that steps one sample through division, integration, multiplies and mixing.
`default_nettype none

module lppm_ctrl #(
   parameter int FRAC_BITS = 8
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  lppm_pkg::status_type status,
   output lppm_pkg::cmd_type    cmd
);
   import lppm_pkg::*;

   localparam int DIV_W = FRAC_BITS + 2;
   localparam int CNT_W = $clog2(DIV_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_INTEG,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM_D,
      ST_TURN,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || rsp_ready;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.lost) begin
               state_in = ST_INTEG;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_W - 1)) begin
                  state_in = ST_INTEG;
               end
            end
         end
         ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_ERR;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = SEL_INTEG;
            cmd.sum_load = 1'b1;
            state_in     = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_DIFF;
            cmd.sum_add = 1'b1;
            state_in    = ST_SUM_D;
         end
         ST_SUM_D: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_TURN;
         end
         ST_TURN: begin
            cmd.turn_en = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DIVIDE)
      else $error("accepted transaction did not start the division");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before its transaction completed");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded without raising valid");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("input accepted while a sample is in progress");

   a_div_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> cnt_ff < DIV_W)
      else $error("division step counter out of range");

endmodule

`default_nettype wire

[sv/lppm_dpath.sv]
// Datapath: error divider, integrator, shared gain multiplier, turn scaling and duty mixer.
`default_nettype none

module lppm_dpath #(
   parameter int FRAC_BITS = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  lppm_pkg::cmd_type                cmd,
   input  lppm_pkg::cfg_type                cfg,
   input  wire  [4:0]                       req_line_bits,
   output lppm_pkg::status_type             status,
   output logic [lppm_pkg::DUTY_W-1:0]      rsp_left_duty,
   output logic [lppm_pkg::DUTY_W-1:0]      rsp_right_duty,
   output logic signed [lppm_pkg::TURN_W-1:0] rsp_turn_value,
   output logic                             rsp_line_lost
);
   import lppm_pkg::*;

   localparam int DIV_W  = FRAC_BITS + 2;
   localparam int ERR_W  = FRAC_BITS + 3;
   localparam int DIFF_W = FRAC_BITS + 4;
   localparam int OP_W   = (INTEG_W > DIFF_W) ? INTEG_W : DIFF_W;
   localparam int PROD_W = GAIN_W + OP_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ISUM_W = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
   localparam int MIX_W  = TURN_W + 2;

   localparam logic signed [SUM_W-1:0] BIAS =
      {{(SUM_W - 2 * FRAC_BITS){1'b0}}, {(2 * FRAC_BITS){1'b1}}};
   localparam logic signed [SUM_W-1:0] TURN_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] TURN_MIN = ~TURN_MAX;
   localparam logic signed [MIX_W-1:0] DUTY_TOP = MIX_W'(MAX_DUTY);

   // Sample decode.
   logic signed [2:0] wsum;
   logic [2:0]        count;
   logic [1:0]        mag;

   // Divider.
   logic [DIV_W-1:0] dvd_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [2:0]       rem_ff;
   logic [2:0]       div_ff;
   logic             neg_ff;
   logic             lost_ff;
   logic [3:0]       trial;
   logic             ge;

   // Integrator and error history.
   logic signed [ERR_W-1:0]   quo_s;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [ISUM_W-1:0]  lim_pos;
   logic signed [ISUM_W-1:0]  lim_neg;
   logic signed [ISUM_W-1:0]  iclamp;

   // Multiply-accumulate.
   logic signed [GAIN_W-1:0] gain_sel;
   logic signed [OP_W-1:0]   op_sel;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff;

   // Turn and mixer.
   logic signed [SUM_W-1:0]  biased;
   logic signed [SUM_W-1:0]  shifted;
   logic signed [TURN_W-1:0] turn_in;
   logic signed [TURN_W-1:0] turn_ff;
   logic signed [MIX_W-1:0]  base_s;
   logic signed [MIX_W-1:0]  left_raw;
   logic signed [MIX_W-1:0]  right_raw;
   logic signed [MIX_W-1:0]  left_cl;
   logic signed [MIX_W-1:0]  right_cl;

   logic [DUTY_W-1:0]        left_ff;
   logic [DUTY_W-1:0]        right_ff;
   logic signed [TURN_W-1:0] turn_out_ff;
   logic                     lost_out_ff;

   always_comb begin
      wsum  = $signed({2'b00, req_line_bits[3]}) + $signed({1'b0, req_line_bits[4], 1'b0})
            - $signed({2'b00, req_line_bits[1]}) - $signed({1'b0, req_line_bits[0], 1'b0});
      count = {2'b00, req_line_bits[0]} + {2'b00, req_line_bits[1]}
            + {2'b00, req_line_bits[2]} + {2'b00, req_line_bits[3]}
            + {2'b00, req_line_bits[4]};
      mag   = wsum[2] ? 2'(-wsum) : wsum[1:0];
   end

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff  <= {mag, {FRAC_BITS{1'b0}}};
         quo_ff  <= '0;
         rem_ff  <= '0;
         div_ff  <= count;
         neg_ff  <= wsum[2];
         lost_ff <= (count == 3'd0);
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? 3'(trial - {1'b0, div_ff}) : trial[2:0];
      end
   end

   assign status.lost = lost_ff;

   always_comb begin
      quo_s   = $signed({1'b0, quo_ff});
      err_in  = lost_ff ? last_err_ff : (neg_ff ? -quo_s : quo_s);
      isum    = ISUM_W'(integ_ff) + ISUM_W'(err_in);
      lim_pos = $signed({{(ISUM_W - 16){1'b0}}, cfg.integ_limit});
      lim_neg = -lim_pos;
      if (err_in == '0) begin
         iclamp = '0;
      end else if (isum > lim_pos) begin
         iclamp = lim_pos;
      end else if (isum < lim_neg) begin
         iclamp = lim_neg;
      end else begin
         iclamp = isum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (cmd.integ) begin
         integ_ff    <= INTEG_W'(iclamp);
         last_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.integ) begin
         diff_ff <= DIFF_W'(err_in) - DIFF_W'(last_err_ff);
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         SEL_ERR: begin
            gain_sel = cfg.prop_gain;
            op_sel   = OP_W'(last_err_ff);
         end
         SEL_INTEG: begin
            gain_sel = cfg.integ_gain;
            op_sel   = OP_W'(integ_ff);
         end
         SEL_DIFF: begin
            gain_sel = cfg.deriv_gain;
            op_sel   = OP_W'(diff_ff);
         end
         default: begin
            gain_sel = '0;
            op_sel   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= gain_sel * op_sel;
      end
      if (cmd.sum_load) begin
         sum_ff <= SUM_W'(prod_ff);
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + SUM_W'(prod_ff);
      end
   end

   always_comb begin
      biased  = sum_ff + (sum_ff[SUM_W-1] ? BIAS : '0);
      shifted = biased >>> (2 * FRAC_BITS);
      if (shifted > TURN_MAX) begin
         turn_in = TURN_W'(TURN_MAX);
      end else if (shifted < TURN_MIN) begin
         turn_in = TURN_W'(TURN_MIN);
      end else begin
         turn_in = TURN_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.turn_en) begin
         turn_ff <= turn_in;
      end
   end

   always_comb begin
      base_s    = $signed({{(MIX_W - DUTY_W){1'b0}}, cfg.base_duty});
      left_raw  = base_s + MIX_W'(turn_ff);
      right_raw = base_s - MIX_W'(turn_ff);
      if (left_raw < 0) begin
         left_cl = '0;
      end else if (left_raw > DUTY_TOP) begin
         left_cl = DUTY_TOP;
      end else begin
         left_cl = left_raw;
      end
      if (right_raw < 0) begin
         right_cl = '0;
      end else if (right_raw > DUTY_TOP) begin
         right_cl = DUTY_TOP;
      end else begin
         right_cl = right_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         left_ff     <= left_cl[DUTY_W-1:0];
         right_ff    <= right_cl[DUTY_W-1:0];
         turn_out_ff <= turn_ff;
         lost_out_ff <= lost_ff;
      end
   end

   assign rsp_left_duty  = left_ff;
   assign rsp_right_duty = right_ff;
   assign rsp_turn_value = turn_out_ff;
   assign rsp_line_lost  = lost_out_ff;

endmodule

`default_nettype wire

[sv/line_position_pid_motor_mixer.sv]
// Top level of the line-position PID motor mixer: register file, sequencer and datapath.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_ready   req_line_bits
//   rsp      out        rsp_valid / rsp_ready   rsp_left_duty, rsp_right_duty,
//                                               rsp_turn_value, rsp_line_lost
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// The time from one sample's acceptance to the next acceptance is set by the
// bit-serial error divider and the single shared gain multiplier; a sample with
// no line bit set skips the division steps of the divider.
// Results sit in an output register, so a new sample is accepted while one waits.
// A stalled result holds the sequencer in its last step until that transaction completes.
// Reset is synchronous; it clears the integral and the stored error and loads the
// register defaults. Register writes are always accepted.
`default_nettype none

module line_position_pid_motor_mixer #(
   parameter int FRAC_BITS = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [4:0]         req_line_bits,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [6:0]         rsp_left_duty,
   output logic [6:0]         rsp_right_duty,
   output logic signed [15:0] rsp_turn_value,
   output logic               rsp_line_lost,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [2:0]         csr_index,
   input  wire  [15:0]        csr_data
);
   import lppm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PROP_GAIN:   cfg_in.prop_gain   = $signed(csr_data);
            CSR_INTEG_GAIN:  cfg_in.integ_gain  = $signed(csr_data);
            CSR_DERIV_GAIN:  cfg_in.deriv_gain  = $signed(csr_data);
            CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_data;
            CSR_BASE_DUTY:   cfg_in.base_duty   = csr_data[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= 16'sd3840;
         cfg_ff.integ_gain  <= 16'sd128;
         cfg_ff.deriv_gain  <= 16'sd1280;
         cfg_ff.integ_limit <= 16'd12800;
         cfg_ff.base_duty   <= 7'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lppm_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lppm_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg_ff),
      .req_line_bits  (req_line_bits),
      .status         (status),
      .rsp_left_duty  (rsp_left_duty),
      .rsp_right_duty (rsp_right_duty),
      .rsp_turn_value (rsp_turn_value),
      .rsp_line_lost  (rsp_line_lost)
   );

endmodule

`default_nettype wire
